@@ design/ccsl_pkg.sv @@
// Shared types and constants of the code section locator.
package ccsl_pkg;

  // Parse phases of the container walker
  typedef enum logic [2:0] {
    PH_MAGIC  = 3'd0,
    PH_HEADER = 3'd1,
    PH_SKIP   = 3'd2,
    PH_FOUND  = 3'd3,
    PH_NONE   = 3'd4,
    PH_RAW    = 3'd5
  } ccsl_phase_e;

  // Result status codes
  typedef enum logic [2:0] {
    ST_RAW         = 3'd0,
    ST_FOUND       = 3'd1,
    ST_TRUNC_TABLE = 3'd2,
    ST_TRUNC_DATA  = 3'd3,
    ST_NONE        = 3'd4
  } ccsl_status_e;

  typedef struct packed {
    logic [30:0]  code_length;
    logic [30:0]  code_offset;
    ccsl_status_e status;
  } ccsl_result_t;

  localparam logic [7:0] MagicBytes [4] = '{8'h41, 8'h49, 8'h4C, 8'h00};
  localparam logic [15:0] CodeType = 16'h0001;
  localparam int unsigned PrefixBytes = 8;
  localparam int unsigned HeaderBytes = 6;
  // Earliest place a code section can start: prefix plus one header
  localparam logic [30:0] FirstSectionOffset = 31'(PrefixBytes + HeaderBytes);

endpackage

@@ design/container_code_section_locator_unit.sv @@
// Top level of the container code section locator: input stage, parser, result register.
//
//  channel   | dir | payload                                   | transfer when
//  s_axis    | in  | tdata[7:0] byte_in, tlast last_byte        | s tvalid & tready
//  m_axis    | out | tdata[2:0] status, [33:3] code_offset,     | m tvalid & tready
//            |     |   [64:34] code_length, [71:65] zero        |
//
// One byte per cycle sustained while no last byte waits on a blocked result register;
// each byte sits in the input register, and the parser state update for it is one
// short combinational step. A result is loaded into the result register and shown
// on m_axis at the edge where its last byte leaves the input register.
// Reset (rst_ni low, asynchronous) empties both stages and returns the parser to the
// magic check. A stalled result holds only the last byte of the next buffer; earlier
// bytes keep flowing into the parser while the result waits.
module container_code_section_locator_unit #(
  parameter int unsigned COUNT_BITS = 31
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] byte_in
  input  logic        s_axis_tlast_i,   // last_byte
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [71:0] m_axis_tdata_o    // [2:0] status, [33:3] code_offset,
                                        // [64:34] code_length, [71:65] zero
);

  logic                  in_valid_q, in_valid_d;
  logic [7:0]            in_byte_q;
  logic                  in_last_q;
  logic                  out_valid_q, out_valid_d;
  ccsl_pkg::ccsl_result_t out_res_q;
  ccsl_pkg::ccsl_result_t step_res;
  logic                  out_free;
  logic                  fire;
  logic                  load;
  logic                  s_xfer;

  // Advance a byte into the parser unless it is a last byte with no room for its result
  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign fire            = in_valid_q && (!in_last_q || out_free);
  assign load            = fire && in_last_q;
  assign s_axis_tready_o = !in_valid_q || fire;
  assign s_xfer          = s_axis_tvalid_i && s_axis_tready_o;

  assign in_valid_d  = s_xfer ? 1'b1 : (fire ? 1'b0 : in_valid_q);
  assign out_valid_d = load ? 1'b1 : (m_axis_tready_i ? 1'b0 : out_valid_q);

  ccsl_parser #(
    .COUNT_BITS(COUNT_BITS)
  ) u_parser (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (fire),
    .byte_i  (in_byte_q),
    .last_i  (in_last_q),
    .result_o(step_res)
  );

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload: hold the input byte and the result until taken
  always_ff @(posedge clk_i) begin
    if (s_xfer) begin
      in_byte_q <= s_axis_tdata_i;
      in_last_q <= s_axis_tlast_i;
    end
    if (load) begin
      out_res_q <= step_res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {7'd0, out_res_q.code_length, out_res_q.code_offset,
                            out_res_q.status};

  // Invalid statuses carry zero offset and length
  a_invalid_fields_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_res_q.status == ccsl_pkg::ST_TRUNC_TABLE ||
                     out_res_q.status == ccsl_pkg::ST_TRUNC_DATA ||
                     out_res_q.status == ccsl_pkg::ST_NONE))
    |-> (out_res_q.code_offset == '0 && out_res_q.code_length == '0))
    else $error("non-zero fields on an invalid status");

  // A code section always starts after the prefix and one header
  a_found_offset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_res_q.status == ccsl_pkg::ST_FOUND)
    |-> (out_res_q.code_offset >= ccsl_pkg::FirstSectionOffset))
    else $error("code section offset inside the header area");

  // A taken result with nothing behind it clears the output
  a_result_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && m_axis_tready_i && !load) |=> !out_valid_q)
    else $error("result repeated after transfer");

  // A last byte never leaves the input stage while the result register is blocked
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !m_axis_tready_i) |-> !load)
    else $error("pending result overwritten");

endmodule

@@ design/ccsl_parser.sv @@
// Parse state and per-byte update of the code section locator.
module ccsl_parser #(
  parameter int unsigned COUNT_BITS = 31
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  step_i,
  input  logic [7:0]            byte_i,
  input  logic                  last_i,
  output ccsl_pkg::ccsl_result_t result_o
);

  localparam logic [COUNT_BITS-1:0] CountMax = '1;

  logic [COUNT_BITS-1:0] cnt_q, cnt_d;
  ccsl_pkg::ccsl_phase_e phase_q, phase_d;
  logic                  match_q, match_d;
  logic [15:0]           total_q, total_d;
  logic [15:0]           done_q, done_d;
  logic [2:0]            idx_q, idx_d;
  logic [15:0]           type_q, type_d;
  logic [31:0]           len_q, len_d;
  logic [31:0]           skip_q, skip_d;
  logic [COUNT_BITS-1:0] foff_q, foff_d;
  logic [COUNT_BITS-1:0] flen_q, flen_d;

  // Next state for one byte
  always_comb begin
    logic [15:0] done_new;
    logic [31:0] skip_new;
    cnt_d    = (cnt_q == CountMax) ? cnt_q : cnt_q + COUNT_BITS'(1);
    phase_d  = phase_q;
    match_d  = match_q;
    total_d  = total_q;
    done_d   = done_q;
    idx_d    = idx_q;
    type_d   = type_q;
    len_d    = len_q;
    skip_d   = skip_q;
    foff_d   = foff_q;
    flen_d   = flen_q;
    done_new = done_q + 16'd1;
    skip_new = (skip_q != 32'd0) ? skip_q - 32'd1 : skip_q;
    case (phase_q)
      ccsl_pkg::PH_MAGIC: begin
        if (cnt_q < COUNT_BITS'(4) && byte_i != ccsl_pkg::MagicBytes[cnt_q[1:0]]) begin
          match_d = 1'b0;
        end
        if (cnt_q == COUNT_BITS'(6)) begin
          total_d = {8'h00, byte_i};
        end else if (cnt_q == COUNT_BITS'(7)) begin
          total_d = {byte_i, total_q[7:0]};
          if (!match_q) begin
            phase_d = ccsl_pkg::PH_RAW;
          end else begin
            done_d = '0;
            if (total_d == 16'd0) begin
              phase_d = ccsl_pkg::PH_NONE;
            end else begin
              phase_d = ccsl_pkg::PH_HEADER;
              idx_d   = '0;
              type_d  = '0;
              len_d   = '0;
            end
          end
        end
      end
      ccsl_pkg::PH_HEADER: begin
        case (idx_q)
          3'd0:    type_d[7:0]   = byte_i;
          3'd1:    type_d[15:8]  = byte_i;
          3'd2:    len_d[7:0]    = byte_i;
          3'd3:    len_d[15:8]   = byte_i;
          3'd4:    len_d[23:16]  = byte_i;
          3'd5:    len_d[31:24]  = byte_i;
          default: ;
        endcase
        if (idx_q >= 3'd5) begin
          done_d = done_new;
          if (type_d == ccsl_pkg::CodeType) begin
            foff_d  = cnt_d;
            flen_d  = (len_d > {{(32-COUNT_BITS){1'b0}}, CountMax}) ?
                      CountMax : len_d[COUNT_BITS-1:0];
            skip_d  = len_d;
            phase_d = ccsl_pkg::PH_FOUND;
          end else if (len_d == 32'd0) begin
            if (done_new >= total_q) begin
              phase_d = ccsl_pkg::PH_NONE;
            end else begin
              phase_d = ccsl_pkg::PH_HEADER;
              idx_d   = '0;
              type_d  = '0;
              len_d   = '0;
            end
          end else begin
            skip_d  = len_d;
            phase_d = ccsl_pkg::PH_SKIP;
          end
        end else begin
          idx_d = idx_q + 3'd1;
        end
      end
      ccsl_pkg::PH_SKIP: begin
        skip_d = skip_new;
        if (skip_new == 32'd0) begin
          if (done_q >= total_q) begin
            phase_d = ccsl_pkg::PH_NONE;
          end else begin
            phase_d = ccsl_pkg::PH_HEADER;
            idx_d   = '0;
            type_d  = '0;
            len_d   = '0;
          end
        end
      end
      ccsl_pkg::PH_FOUND: skip_d = skip_new;
      default: ;
    endcase
  end

  // Result as seen after this byte
  always_comb begin
    result_o = '0;
    case (phase_d)
      ccsl_pkg::PH_MAGIC, ccsl_pkg::PH_RAW: begin
        result_o.status      = ccsl_pkg::ST_RAW;
        result_o.code_length = 31'(cnt_d);
      end
      ccsl_pkg::PH_HEADER: result_o.status = ccsl_pkg::ST_TRUNC_TABLE;
      ccsl_pkg::PH_SKIP:   result_o.status = ccsl_pkg::ST_TRUNC_DATA;
      ccsl_pkg::PH_FOUND: begin
        if (skip_d == 32'd0) begin
          result_o.status      = ccsl_pkg::ST_FOUND;
          result_o.code_offset = 31'(foff_d);
          result_o.code_length = 31'(flen_d);
        end else begin
          result_o.status = ccsl_pkg::ST_TRUNC_DATA;
        end
      end
      default: result_o.status = ccsl_pkg::ST_NONE;
    endcase
  end

  // Register the parser state on each step; return to reset state after the last byte of a buffer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      phase_q <= ccsl_pkg::PH_MAGIC;
      match_q <= 1'b1;
      total_q <= '0;
      done_q  <= '0;
      idx_q   <= '0;
      type_q  <= '0;
      len_q   <= '0;
      skip_q  <= '0;
      foff_q  <= '0;
      flen_q  <= '0;
    end else if (step_i) begin
      if (last_i) begin
        cnt_q   <= '0;
        phase_q <= ccsl_pkg::PH_MAGIC;
        match_q <= 1'b1;
        total_q <= '0;
        done_q  <= '0;
        idx_q   <= '0;
        type_q  <= '0;
        len_q   <= '0;
        skip_q  <= '0;
        foff_q  <= '0;
        flen_q  <= '0;
      end else begin
        cnt_q   <= cnt_d;
        phase_q <= phase_d;
        match_q <= match_d;
        total_q <= total_d;
        done_q  <= done_d;
        idx_q   <= idx_d;
        type_q  <= type_d;
        len_q   <= len_d;
        skip_q  <= skip_d;
        foff_q  <= foff_d;
        flen_q  <= flen_d;
      end
    end
  end

endmodule

@@ verif/section_locator_checker.sv @@
// Stream checker for the code section locator: walks each input byte, predicts results and compares.
module section_locator_checker #(
  parameter int unsigned COUNT_BITS = 31
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_tvalid_i,
  input  logic              s_tready_i,
  input  logic [7:0]        s_tdata_i,
  input  logic              s_tlast_i,
  input  logic              m_tvalid_i,
  input  logic              m_tready_i,
  input  logic [71:0]       m_tdata_i,
  output int unsigned       fail_count_o,
  output int unsigned       pending_o
);

  timeunit 1ns;
  timeprecision 1ps;

  // Magic word as it arrives, first byte in the lowest bits
  localparam logic [31:0] ContainerMagic   = 32'h004C_4941;
  localparam logic [15:0] CodeSectionType  = 16'h0001;
  localparam logic [30:0] CountMax         = 31'((64'd1 << COUNT_BITS) - 64'd1);

  // Walker state
  logic [30:0]             byte_cnt;
  ccsl_pkg::ccsl_phase_e   phase;
  logic                    magic_ok;
  logic [15:0]             sec_total;
  logic [15:0]             sec_seen;
  logic [2:0]              hdr_idx;
  logic [15:0]             sec_type;
  logic [31:0]             sec_len;
  logic [31:0]             skip_left;
  logic [30:0]             code_off;
  logic [31:0]             code_len;

  ccsl_pkg::ccsl_result_t  located_q [$];

  function automatic void clear_walker();
    byte_cnt  = '0;
    phase     = ccsl_pkg::PH_MAGIC;
    magic_ok  = 1'b1;
    sec_total = '0;
    sec_seen  = '0;
    hdr_idx   = '0;
    sec_type  = '0;
    sec_len   = '0;
    skip_left = '0;
    code_off  = '0;
    code_len  = '0;
  endfunction

  // Either start the next header or declare the table exhausted
  function automatic void open_next_section();
    if (sec_seen >= sec_total) begin
      phase = ccsl_pkg::PH_NONE;
    end else begin
      phase    = ccsl_pkg::PH_HEADER;
      hdr_idx  = '0;
      sec_type = '0;
      sec_len  = '0;
    end
  endfunction

  function automatic void walk_container_byte(input logic [7:0] b, input logic last);
    logic [30:0]            pos;
    ccsl_pkg::ccsl_result_t res;
    pos = byte_cnt;
    if (byte_cnt < CountMax) byte_cnt = byte_cnt + 31'd1;

    case (phase)
      ccsl_pkg::PH_MAGIC: begin
        if (pos < 4 && b != ContainerMagic[8 * pos[1:0] +: 8]) magic_ok = 1'b0;
        if (pos == 6) begin
          sec_total = {8'h00, b};
        end else if (pos == 7) begin
          sec_total[15:8] = b;
          if (!magic_ok) begin
            phase = ccsl_pkg::PH_RAW;
          end else begin
            sec_seen = '0;
            open_next_section();
          end
        end
      end
      ccsl_pkg::PH_HEADER: begin
        if (hdr_idx < 2) sec_type = sec_type | (16'(b) << (8 * hdr_idx));
        else if (hdr_idx < 6) sec_len = sec_len | (32'(b) << (8 * (hdr_idx - 2)));
        if (hdr_idx >= 5) begin
          sec_seen = sec_seen + 16'd1;
          if (sec_type == CodeSectionType) begin
            code_off  = byte_cnt;
            code_len  = sec_len;
            skip_left = sec_len;
            phase     = ccsl_pkg::PH_FOUND;
          end else if (sec_len == 0) begin
            open_next_section();
          end else begin
            skip_left = sec_len;
            phase     = ccsl_pkg::PH_SKIP;
          end
        end else begin
          hdr_idx = hdr_idx + 3'd1;
        end
      end
      ccsl_pkg::PH_SKIP: begin
        if (skip_left > 0) skip_left = skip_left - 32'd1;
        if (skip_left == 0) open_next_section();
      end
      ccsl_pkg::PH_FOUND: begin
        if (skip_left > 0) skip_left = skip_left - 32'd1;
      end
      default: ;
    endcase

    if (!last) return;

    res.status      = ccsl_pkg::ST_NONE;
    res.code_offset = '0;
    res.code_length = '0;
    case (phase)
      ccsl_pkg::PH_MAGIC, ccsl_pkg::PH_RAW: begin
        res.status      = ccsl_pkg::ST_RAW;
        res.code_length = byte_cnt;
      end
      ccsl_pkg::PH_HEADER: res.status = ccsl_pkg::ST_TRUNC_TABLE;
      ccsl_pkg::PH_SKIP:   res.status = ccsl_pkg::ST_TRUNC_DATA;
      ccsl_pkg::PH_FOUND: begin
        if (skip_left == 0) begin
          res.status      = ccsl_pkg::ST_FOUND;
          res.code_offset = code_off;
          res.code_length = (code_len > 32'(CountMax)) ? CountMax : code_len[30:0];
        end else begin
          res.status = ccsl_pkg::ST_TRUNC_DATA;
        end
      end
      default: res.status = ccsl_pkg::ST_NONE;
    endcase
    located_q.push_back(res);
    clear_walker();
  endfunction

  function automatic void report(input string what, input logic [31:0] exp_v,
                                 input logic [31:0] act_v);
    $display("%0t: %s mismatch: expected %0d actual %0d", $time, what, exp_v, act_v);
    fail_count_o = fail_count_o + 1;
  endfunction

  function automatic void check_located(input logic [71:0] data);
    ccsl_pkg::ccsl_result_t want;
    if (located_q.size() == 0) begin
      $display("%0t: unexpected result: expected none actual status %0d offset %0d length %0d",
               $time, data[2:0], data[33:3], data[64:34]);
      fail_count_o = fail_count_o + 1;
      return;
    end
    want = located_q.pop_front();
    if (data[2:0] != want.status) report("status", 32'(want.status), 32'(data[2:0]));
    if (data[33:3] != want.code_offset)
      report("code_offset", 32'(want.code_offset), 32'(data[33:3]));
    if (data[64:34] != want.code_length)
      report("code_length", 32'(want.code_length), 32'(data[64:34]));
    if (data[71:65] != '0) report("padding", 32'd0, 32'(data[71:65]));
  endfunction

  // Compare before walking: a result never belongs to a byte taken at the same edge
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      clear_walker();
      located_q.delete();
      fail_count_o = 0;
    end else begin
      if (m_tvalid_i && m_tready_i) check_located(m_tdata_i);
      if (s_tvalid_i && s_tready_i) walk_container_byte(s_tdata_i, s_tlast_i);
    end
    pending_o = located_q.size();
  end

endmodule

@@ verif/tb.sv @@
// Testbench top for the code section locator: clock, reset, byte stream stimulus and verdict.
module tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned TargetBytes  = 700;
  localparam int unsigned MinBuffers   = 50;
  localparam int unsigned CycleLimit   = 300_000;
  localparam int unsigned DrainCycles  = 10;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [7:0]  s_axis_tdata_i = 8'h00;   // [7:0] byte_in
  logic        s_axis_tlast_i = 1'b0;    // last_byte
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [71:0] m_axis_tdata_o;           // [2:0] status, [33:3] code_offset,
                                         // [64:34] code_length, [71:65] zero

  int unsigned fail_count;
  int unsigned pending;
  int unsigned cycle_cnt = 0;
  int unsigned src_idle_pct = 8;
  int unsigned sink_idle_pct = 51;
  int unsigned bytes_sent = 0;
  int unsigned buffers_sent = 0;

  logic [7:0]  frame_q [$];

  always #2 clk_i = ~clk_i;

  container_code_section_locator_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  section_locator_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_tvalid_i   (s_axis_tvalid_i),
    .s_tready_i   (s_axis_tready_o),
    .s_tdata_i    (s_axis_tdata_i),
    .s_tlast_i    (s_axis_tlast_i),
    .m_tvalid_i   (m_axis_tvalid_o),
    .m_tready_i   (m_axis_tready_i),
    .m_tdata_i    (m_axis_tdata_o),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // Receiver back-pressure, redrawn every cycle
  always @(negedge clk_i) begin
    m_axis_tready_i <= ($urandom_range(99) >= sink_idle_pct);
  end

  // Hard stop if the stream hangs
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("%0t: cycle limit reached", $time);
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic void push_random(input int unsigned n);
    for (int unsigned i = 0; i < n; i++) frame_q.push_back(8'($urandom_range(255)));
  endfunction

  // Magic, two ignored bytes, little-endian section count
  function automatic void push_prefix(input logic [15:0] count);
    frame_q.push_back(8'h41);
    frame_q.push_back(8'h49);
    frame_q.push_back(8'h4C);
    frame_q.push_back(8'h00);
    push_random(2);
    frame_q.push_back(count[7:0]);
    frame_q.push_back(count[15:8]);
  endfunction

  function automatic void push_header(input logic [15:0] kind, input logic [31:0] len);
    frame_q.push_back(kind[7:0]);
    frame_q.push_back(kind[15:8]);
    for (int i = 0; i < 4; i++) frame_q.push_back(len[8 * i +: 8]);
  endfunction

  function automatic logic [15:0] pick_type();
    int unsigned r;
    r = $urandom_range(9);
    case (r)
      0, 1, 2, 3: return 16'h0001;
      4:          return 16'h0000;
      5:          return 16'h0100;   // code type in the wrong byte
      6:          return 16'hFFFF;
      7:          return 16'h0101;
      default:    return 16'($urandom_range(16'hFFFF));
    endcase
  endfunction

  function automatic logic [31:0] pick_length();
    int unsigned r;
    r = $urandom_range(9);
    case (r)
      0, 1:    return 32'd0;
      8:       return 32'($urandom());
      9:       return 32'($urandom_range(40, 7));
      default: return 32'($urandom_range(6));
    endcase
  endfunction

  // Mostly well-formed containers with random content; the rest broken magic or noise
  function automatic void build_random_frame();
    int unsigned pick, nsec, nhdr, ln, cut, idx;
    logic [15:0] kind;
    logic [31:0] len;
    bit          stop;
    pick = $urandom_range(99);
    if (pick < 70) begin
      nsec = ($urandom_range(9) == 0) ? $urandom_range(16'hFFFF) : $urandom_range(4);
      push_prefix(16'(nsec));
      nhdr = (nsec < 4) ? nsec : 4;
      stop = 1'b0;
      for (int unsigned s = 0; s < nhdr && !stop; s++) begin
        kind = pick_type();
        len  = pick_length();
        push_header(kind, len);
        ln = (len > 12) ? $urandom_range(12) : len;
        push_random(ln);
        if (kind == 16'h0001 || ln != len) stop = 1'b1;
      end
      push_random($urandom_range(3));
      // Cut short now and then to land inside the prefix, a header or section data
      if ($urandom_range(99) < 35) begin
        cut = $urandom_range(frame_q.size(), 1);
        while (frame_q.size() > cut) void'(frame_q.pop_back());
      end
    end else if (pick < 85) begin
      push_prefix(16'($urandom_range(3)));
      idx = $urandom_range(3);
      frame_q[idx] = frame_q[idx] ^ (8'h01 << $urandom_range(7));
      push_random($urandom_range(16));
    end else begin
      push_random($urandom_range(20, 1));
    end
  endfunction

  // Send frame_q as one buffer; leaves tvalid high so the next buffer can follow at once
  task automatic send_frame();
    int unsigned n;
    n = frame_q.size();
    for (int unsigned i = 0; i < n; i++) begin
      while ($urandom_range(99) < src_idle_pct) begin
        s_axis_tvalid_i <= 1'b0;
        @(negedge clk_i);
      end
      s_axis_tvalid_i <= 1'b1;
      s_axis_tdata_i  <= frame_q[i];
      s_axis_tlast_i  <= (i == n - 1);
      @(posedge clk_i);
      while (!s_axis_tready_o) @(posedge clk_i);
      @(negedge clk_i);
    end
    bytes_sent   += n;
    buffers_sent += 1;
    frame_q.delete();
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed buffers
    // one-byte buffer: raw
    frame_q.push_back(8'hFF);
    send_frame();
    // seven bytes with good magic: still too short, raw
    frame_q = '{8'h41, 8'h49, 8'h4C, 8'h00, 8'h00, 8'hFF, 8'h01};
    send_frame();
    // no sections, with trailing bytes ignored
    push_prefix(16'h0000);
    push_random(2);
    send_frame();
    // broken third magic byte: raw over the whole buffer
    frame_q = '{8'h41, 8'h49, 8'h4D, 8'h00, 8'h00, 8'h00, 8'h01, 8'h00, 8'h00};
    send_frame();
    // plain code section with extra bytes after its data
    push_prefix(16'h0001);
    push_header(16'h0001, 32'd3);
    push_random(5);
    send_frame();
    // empty non-code section, then empty code section
    push_prefix(16'h0002);
    push_header(16'h0002, 32'd0);
    push_header(16'h0001, 32'd0);
    send_frame();
    // buffer ends inside the second header
    push_prefix(16'h0003);
    push_header(16'h0100, 32'd2);
    push_random(5);
    send_frame();
    // buffer ends inside skipped data
    push_prefix(16'h0001);
    push_header(16'h0005, 32'h0000_0100);
    push_random(4);
    send_frame();
    // code section claims the full unsigned length: data cut short
    push_prefix(16'h0001);
    push_header(16'h0001, 32'hFFFF_FFFF);
    push_random(3);
    send_frame();
    // table exhausted without a code section
    push_prefix(16'h0001);
    push_header(16'hFFFF, 32'd1);
    push_random(1);
    send_frame();
    // large count, buffer ends right after the first section
    push_prefix(16'hFFFF);
    push_header(16'h0003, 32'd2);
    push_random(2);
    send_frame();
    // exactly the prefix with one section announced
    push_prefix(16'h0001);
    send_frame();

    // Random buffers across the three idling phases
    while (bytes_sent < TargetBytes || buffers_sent < MinBuffers) begin
      if (bytes_sent < TargetBytes / 3) begin
        src_idle_pct  = 8;
        sink_idle_pct = 51;
      end else if (bytes_sent < 2 * TargetBytes / 3) begin
        src_idle_pct  = 51;
        sink_idle_pct = 8;
      end else begin
        src_idle_pct  = 0;
        sink_idle_pct = 0;
      end
      build_random_frame();
      send_frame();
    end
    s_axis_tvalid_i <= 1'b0;
    s_axis_tlast_i  <= 1'b0;

    // Drain outstanding results, then leave room for stray ones
    while (pending != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);

    if (pending != 0) $display("%0t: %0d expected results never arrived", $time, pending);
    if (fail_count == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

@@ sim.f @@
design/ccsl_pkg.sv
design/ccsl_parser.sv
design/container_code_section_locator_unit.sv
verif/section_locator_checker.sv
verif/tb.sv
